// ----- rtl/core/bda_pkg.sv -----
// Package for the binary-to-decimal ASCII core: sizes, character codes,
// shared types and the emitter state encoding. No dependencies.
package bda_pkg;

	localparam int DATA_BITS  = 16;
	localparam int MAX_CHARS  = 19;
	localparam int WREQ_W     = 6;
	localparam int CHAR_W     = 6;
	// Decimal digits needed for a DATA_BITS-wide magnitude (log10(2) ~ 0.30103)
	localparam int NUM_DIGITS = (DATA_BITS * 30103) / 100000 + 1;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int CNT_W      = $clog2(DATA_BITS);
	localparam int LEN_W      = 6;
	localparam int IDX_W      = $clog2(MAX_CHARS);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

	typedef logic [3:0] bcd_digit_t;
	typedef bcd_digit_t [NUM_DIGITS-1:0] bcd_vec_t;

	// Conversion launch, from the top level to the emitter
	typedef struct packed {
		logic              start;
		logic              neg;
		logic [WREQ_W-2:0] width;
	} start_t;

	typedef enum logic [1:0] {
		EM_IDLE,
		EM_WAIT,
		EM_SIZE,
		EM_EMIT
	} emit_state_t;

endpackage

// ----- rtl/core/bda_req_if.sv -----
// Request channel: one word to convert plus its width request.
// Depends on bda_pkg.
interface bda_req_if;
	import bda_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [DATA_BITS-1:0]     value;
	logic signed [WREQ_W-1:0] width_request;

	modport source (output valid, output value, output width_request, input ready);
	modport sink (input valid, input value, input width_request, output ready);

endinterface

// ----- rtl/core/bda_char_if.sv -----
// Character channel: one ASCII character per transfer, last flag on the final one.
// Depends on bda_pkg.
interface bda_char_if;
	import bda_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] text_char;
	logic              last;

	modport source (output valid, output text_char, output last, input ready);
	modport sink (input valid, input text_char, input last, output ready);

endinterface

// ----- rtl/core/binary_to_decimal_ascii_core.sv -----
// Top level of the binary-to-decimal ASCII core: request decode, serial
// converter and character emitter. Depends on bda_pkg, bda_req_if, bda_char_if.
//
//   port   direction  payload                         transfer
//   req    in         value[15:0], width_request[5:0]  one word per request
//   text   out        text_char[5:0], last             one character each
//
// A request is converted by the bit-serial BCD shifter, sized in the EM_SIZE
// state, and its first character is then registered in EM_EMIT; characters
// then follow one per cycle while text is not stalled.
// arst_n clears all control state; no memory clearing pass is needed.
// A stall on text holds the character register; req.ready stays low until
// the last character of the current request is registered.
module binary_to_decimal_ascii_core (
	input  logic     clk,
	input  logic     arst_n,
	bda_req_if.sink  req,
	bda_char_if.source text
);
	import bda_pkg::*;

	logic                 accept;
	logic                 neg;
	logic [DATA_BITS-1:0] mag;
	start_t               launch;
	bcd_vec_t             digits;
	logic                 conv_done;
	logic                 emit_busy;

	assign accept = req.valid && req.ready;

	// Decode the request: sign handling and minimum width
	always_comb begin
		neg          = req.width_request[WREQ_W-1] && req.value[DATA_BITS-1];
		mag          = neg ? (~req.value + 1'b1) : req.value;
		launch.start = accept;
		launch.neg   = neg;
		launch.width = req.width_request[WREQ_W-1] ? '0 : req.width_request[WREQ_W-2:0];
	end

	assign req.ready = !emit_busy;

	bda_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mag    (mag),
		.digits (digits),
		.done   (conv_done)
	);

	bda_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.launch    (launch),
		.conv_done (conv_done),
		.digits    (digits),
		.busy      (emit_busy),
		.text      (text)
	);

endmodule

// ----- rtl/core/bda_dabble.sv -----
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on bda_pkg.
module bda_dabble (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bda_pkg::DATA_BITS-1:0] mag,
	output bda_pkg::bcd_vec_t             digits,
	output logic                          done
);
	import bda_pkg::*;

	logic [DATA_BITS-1:0] mag_q;
	bcd_vec_t             bcd_q;
	bcd_vec_t             adj;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	// Add 3 to every digit of five or more before the shift
	always_comb begin
		for (int k = 0; k < NUM_DIGITS; k++) begin
			adj[k] = (bcd_q[k] >= 4'd5) ? bcd_q[k] + 4'd3 : bcd_q[k];
		end
	end

	// Sequence control: count DATA_BITS shifts, pulse done after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Shift the magnitude MSB first into the BCD register
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[DATA_BITS-2:0], 1'b0};
			bcd_q <= BCD_W'({adj, mag_q[DATA_BITS-1]});
		end
	end

	assign digits = bcd_q;
	assign done   = done_q;

endmodule

// ----- rtl/core/bda_emit.sv -----
// Character emitter: sizes the text, then sends sign and digits MSB first
// through an output register. Depends on bda_pkg and bda_char_if.
module bda_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  bda_pkg::start_t   launch,
	input  logic              conv_done,
	input  bda_pkg::bcd_vec_t digits,
	output logic              busy,
	bda_char_if.source        text
);
	import bda_pkg::*;

	emit_state_t          state_q;
	emit_state_t          state_d;
	logic                 neg_q;
	logic                 sign_q;
	logic [WREQ_W-2:0]    width_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 valid_q;
	logic [CHAR_W-1:0]    char_q;
	logic                 last_q;
	logic                 slot_free;
	logic                 load;
	logic                 final_char;
	logic [CHAR_W-1:0]    next_char;
	bcd_digit_t           dig;
	logic [LEN_W-1:0]     nd;
	logic [LEN_W-1:0]     room;
	logic [LEN_W-1:0]     len;

	assign slot_free  = !valid_q || text.ready;
	assign final_char = !sign_q && (idx_q == '0);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			EM_IDLE: if (launch.start) state_d = EM_WAIT;
			EM_WAIT: if (conv_done) state_d = EM_SIZE;
			EM_SIZE: state_d = EM_EMIT;
			EM_EMIT: if (load && final_char) state_d = EM_IDLE;
			default: state_d = EM_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		load = 1'b0;
		case (state_q)
			EM_EMIT: load = slot_free;
			default: load = 1'b0;
		endcase
	end

	// Pick the digit at the current position; above the BCD register it is zero
	always_comb begin
		dig = '0;
		for (int k = 0; k < NUM_DIGITS; k++) begin
			if (LEN_W'(idx_q) == LEN_W'(k)) dig = digits[k];
		end
		next_char = sign_q ? CHAR_MINUS : CHAR_ZERO + CHAR_W'(dig);
	end

	// Text length: significant digits, padded to the width, capped to fit
	always_comb begin
		nd = LEN_W'(1);
		for (int k = 1; k < NUM_DIGITS; k++) begin
			if (digits[k] != '0) nd = LEN_W'(k + 1);
		end
		room = LEN_W'(MAX_CHARS) - LEN_W'(neg_q);
		len  = (LEN_W'(width_q) > nd) ? LEN_W'(width_q) : nd;
		if (len > room) len = room;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EM_IDLE;
			valid_q <= 1'b0;
			sign_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) valid_q <= 1'b1;
			else if (text.ready) valid_q <= 1'b0;
			if (state_q == EM_IDLE && launch.start) sign_q <= launch.neg;
			else if (load) sign_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == EM_IDLE && launch.start) begin
			neg_q   <= launch.neg;
			width_q <= launch.width;
		end
		if (state_q == EM_SIZE) idx_q <= IDX_W'(len - LEN_W'(1));
		else if (load && !sign_q && idx_q != '0) idx_q <= idx_q - 1'b1;
		if (load) begin
			char_q <= next_char;
			last_q <= final_char;
		end
	end

	assign busy           = (state_q != EM_IDLE);
	assign text.valid     = valid_q;
	assign text.text_char = char_q;
	assign text.last      = last_q;

endmodule

// ----- rtl/core/bda_checker.sv -----
// Port-level checks for the binary-to-decimal ASCII core, bound to the top.
// Depends on bda_pkg.
module bda_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [bda_pkg::CHAR_W-1:0] text_char,
	input logic                       last
);
	import bda_pkg::*;

	// Hold off further requests right after one is taken
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while previous one in progress");

	// Only a minus sign or a decimal digit is sent
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (text_char == CHAR_MINUS) ||
			(text_char >= CHAR_ZERO && text_char <= CHAR_ZERO + CHAR_W'(9)))
		else $error("character outside the decimal set");

	// A sign is always followed by a digit
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && text_char == CHAR_MINUS |-> !last)
		else $error("minus sign flagged as last character");

	// Stalled character holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(text_char) && $stable(last))
		else $error("stalled character changed");

endmodule

bind binary_to_decimal_ascii_core bda_checker u_bda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (text.valid),
	.out_ready (text.ready),
	.text_char (text.text_char),
	.last      (text.last)
);
